### sv/cau_pkg.sv
package cau_pkg;

   // Default number of fraction bits of the fixed-point words.
   localparam int FRAC_BITS_DEF = 16;

   // Word widths: operands, products and the long-division remainder.
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int REM_W  = 96;

   // Operation codes.
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_MAG  = 3'd5
   } op_type;

   // A saturated word with its overflow flag.
   typedef struct packed {
      logic        ov;
      logic [31:0] val;
   } sat_type;

   // Word carried through the division and square-root stages.
   typedef struct packed {
      logic         valid;
      op_type       op;
      logic         ov_s;
      logic [31:0]  re_s;
      logic [31:0]  im_s;
      logic         zd;
      logic [63:0]  den;
      logic         neg_re;
      logic         neg_im;
      logic         ovq_re;
      logic         ovq_im;
      logic [95:0]  rem_re;
      logic [95:0]  rem_im;
      logic [31:0]  q_re;
      logic [31:0]  q_im;
      logic [63:0]  sq_n;
      logic [63:0]  sq_res;
   } iter_type;

   // Saturates a wide signed value to the 32-bit limits.
   function automatic sat_type sat32(input logic signed [65:0] v);
      sat_type r;
      if (v > $signed({34'b0, 32'h7FFFFFFF})) begin
         r.ov  = 1'b1;
         r.val = 32'h7FFFFFFF;
      end else if (v < $signed({{34{1'b1}}, 32'h80000000})) begin
         r.ov  = 1'b1;
         r.val = 32'h80000000;
      end else begin
         r.ov  = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

endpackage

### sv/complex_arithmetic_unit.sv
// Complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// A command word is taken at a rising edge where start is high and busy is
// low: the operation code and the two complex operands a and b. Operations
// are add, subtract, multiply, divide, conjugate of a and magnitude of a.
// Each command gives one result word, shown on the rsp_ ports for exactly
// one cycle with rsp_valid high. Parts that do not fit in 32 bits saturate
// and raise rsp_overflow; a divide by zero gives 0+0i and rsp_zero_divisor.
// The path from the accepting edge to the result is the same for every
// operation, so results leave in order. A new command may be given in
// every cycle: one per cycle sustained. The depth is set by the 32
// restoring steps of the quotient, one bit per stage, which the square
// root shares stage for stage, after a multiplier stage, a sum stage and
// a set-up stage and before the output stage. busy is high only during
// reset. Reset empties the pipeline; words in flight are dropped. There is
// no back-pressure on the result side, so the pipeline never stalls.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   output logic               rsp_valid,
   output logic [31:0]        rsp_out_real,
   output logic [31:0]        rsp_out_imag,
   output logic               rsp_zero_divisor,
   output logic               rsp_overflow
);

   localparam int STEPS = cau_pkg::WORD_W;
   localparam int LAT   = STEPS + 4;

   // Stage one: products and the simple operations.
   logic                       s1_valid_ff;
   cau_pkg::op_type            s1_op_ff;
   logic                       s1_ov_ff;
   logic [31:0]                s1_re_ff, s1_im_ff;
   logic signed [63:0]         p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   cau_pkg::op_type            op_in;
   cau_pkg::sat_type           re1_in, im1_in;
   logic signed [31:0]         sq_x, sq_y;
   logic                       accept;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign op_in  = cau_pkg::op_type'(req_operation);
   assign sq_x   = (op_in == cau_pkg::OP_MAG) ? req_a_real : req_b_real;
   assign sq_y   = (op_in == cau_pkg::OP_MAG) ? req_a_imag : req_b_imag;

   always_comb begin
      re1_in = '0;
      im1_in = '0;
      unique case (op_in)
         cau_pkg::OP_ADD: begin
            re1_in = cau_pkg::sat32(66'(req_a_real) + 66'(req_b_real));
            im1_in = cau_pkg::sat32(66'(req_a_imag) + 66'(req_b_imag));
         end
         cau_pkg::OP_SUB: begin
            re1_in = cau_pkg::sat32(66'(req_a_real) - 66'(req_b_real));
            im1_in = cau_pkg::sat32(66'(req_a_imag) - 66'(req_b_imag));
         end
         cau_pkg::OP_CONJ: begin
            re1_in = cau_pkg::sat32(66'(req_a_real));
            im1_in = cau_pkg::sat32(-66'(req_a_imag));
         end
         default: begin
            re1_in = '0;
            im1_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_valid_ff <= accept & ~reset;
      s1_op_ff    <= op_in;
      s1_ov_ff    <= re1_in.ov | im1_in.ov;
      s1_re_ff    <= re1_in.val;
      s1_im_ff    <= im1_in.val;
      p0_ff       <= req_a_real * req_b_real;
      p1_ff       <= req_a_imag * req_b_imag;
      p2_ff       <= req_a_real * req_b_imag;
      p3_ff       <= req_a_imag * req_b_real;
      p4_ff       <= sq_x * sq_x;
      p5_ff       <= sq_y * sq_y;
   end

   // Stage two: sums of products; the multiply result is finished here.
   logic                       s2_valid_ff;
   cau_pkg::op_type            s2_op_ff;
   logic                       s2_ov_ff;
   logic [31:0]                s2_re_ff, s2_im_ff;
   logic signed [64:0]         nr_ff, ni_ff;
   logic [63:0]                den_ff;
   logic signed [65:0]         mre_full, mim_full;
   cau_pkg::sat_type           mre, mim;

   assign mre_full = (66'(p0_ff) - 66'(p1_ff)) >>> FRAC_BITS;
   assign mim_full = (66'(p2_ff) + 66'(p3_ff)) >>> FRAC_BITS;
   assign mre      = cau_pkg::sat32(mre_full);
   assign mim      = cau_pkg::sat32(mim_full);

   always_ff @(posedge clock) begin
      s2_valid_ff <= s1_valid_ff & ~reset;
      s2_op_ff    <= s1_op_ff;
      if (s1_op_ff == cau_pkg::OP_MUL) begin
         s2_ov_ff <= mre.ov | mim.ov;
         s2_re_ff <= mre.val;
         s2_im_ff <= mim.val;
      end else begin
         s2_ov_ff <= s1_ov_ff;
         s2_re_ff <= s1_re_ff;
         s2_im_ff <= s1_im_ff;
      end
      nr_ff  <= 65'(p0_ff) + 65'(p1_ff);
      ni_ff  <= 65'(p3_ff) - 65'(p2_ff);
      den_ff <= $unsigned(p4_ff) + $unsigned(p5_ff);
   end

   // Stage three: signs, magnitudes and the quotient range check.
   cau_pkg::iter_type          it_ff [0:STEPS];
   cau_pkg::iter_type          it0_in;
   logic [64:0]                mag_re, mag_im;
   logic [95:0]                num_re, num_im, den_top;

   assign mag_re  = nr_ff[64] ? $unsigned(-nr_ff) : $unsigned(nr_ff);
   assign mag_im  = ni_ff[64] ? $unsigned(-ni_ff) : $unsigned(ni_ff);
   assign num_re  = 96'(mag_re[63:0]) << FRAC_BITS;
   assign num_im  = 96'(mag_im[63:0]) << FRAC_BITS;
   assign den_top = 96'(den_ff) << STEPS;

   always_comb begin
      it0_in        = '0;
      it0_in.valid  = s2_valid_ff;
      it0_in.op     = s2_op_ff;
      it0_in.ov_s   = s2_ov_ff;
      it0_in.re_s   = s2_re_ff;
      it0_in.im_s   = s2_im_ff;
      it0_in.zd     = (den_ff == '0);
      it0_in.den    = den_ff;
      it0_in.neg_re = nr_ff[64];
      it0_in.neg_im = ni_ff[64];
      it0_in.ovq_re = (num_re >= den_top);
      it0_in.ovq_im = (num_im >= den_top);
      it0_in.rem_re = num_re;
      it0_in.rem_im = num_im;
      it0_in.sq_n   = den_ff;
   end

   always_ff @(posedge clock) begin
      it_ff[0] <= it0_in;
      if (reset) begin
         it_ff[0].valid <= 1'b0;
      end
   end

   // Stages four on: one quotient bit and one root bit per stage.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int          SH     = STEPS - 1 - k;
      localparam logic [63:0] SQ_BIT = 64'd1 << (2 * SH);
      cau_pkg::iter_type      it_in;
      logic [95:0]            dsh;
      logic [64:0]            trial;

      assign dsh   = 96'(it_ff[k].den) << SH;
      assign trial = 65'(it_ff[k].sq_res) + 65'(SQ_BIT);

      always_comb begin
         it_in = it_ff[k];
         if (it_ff[k].rem_re >= dsh) begin
            it_in.rem_re   = it_ff[k].rem_re - dsh;
            it_in.q_re[SH] = 1'b1;
         end
         if (it_ff[k].rem_im >= dsh) begin
            it_in.rem_im   = it_ff[k].rem_im - dsh;
            it_in.q_im[SH] = 1'b1;
         end
         if (65'(it_ff[k].sq_n) >= trial) begin
            it_in.sq_n   = it_ff[k].sq_n - trial[63:0];
            it_in.sq_res = (it_ff[k].sq_res >> 1) + SQ_BIT;
         end else begin
            it_in.sq_res = it_ff[k].sq_res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         it_ff[k+1] <= it_in;
         if (reset) begin
            it_ff[k+1].valid <= 1'b0;
         end
      end
   end

   // Output stage: pick the result for the operation and saturate.
   cau_pkg::iter_type          fin;
   logic                       rsp_valid_ff;
   logic [31:0]                re_ff, im_ff, re_in, im_in;
   logic                       zd_ff, ov_ff, zd_in, ov_in;
   logic                       sat_re, sat_im;

   assign fin = it_ff[STEPS];

   always_comb begin
      re_in  = '0;
      im_in  = '0;
      zd_in  = 1'b0;
      ov_in  = 1'b0;
      sat_re = fin.ovq_re | fin.q_re[31] & (~fin.neg_re | (|fin.q_re[30:0]));
      sat_im = fin.ovq_im | fin.q_im[31] & (~fin.neg_im | (|fin.q_im[30:0]));
      unique case (fin.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_CONJ: begin
            re_in = fin.re_s;
            im_in = fin.im_s;
            ov_in = fin.ov_s;
         end
         cau_pkg::OP_DIV: begin
            if (fin.zd) begin
               zd_in = 1'b1;
            end else begin
               if (sat_re) begin
                  re_in = fin.neg_re ? 32'h80000000 : 32'h7FFFFFFF;
               end else begin
                  re_in = fin.neg_re ? (~fin.q_re + 32'd1) : fin.q_re;
               end
               if (sat_im) begin
                  im_in = fin.neg_im ? 32'h80000000 : 32'h7FFFFFFF;
               end else begin
                  im_in = fin.neg_im ? (~fin.q_im + 32'd1) : fin.q_im;
               end
               ov_in = sat_re | sat_im;
            end
         end
         cau_pkg::OP_MAG: begin
            if (fin.sq_res[63:31] != '0) begin
               re_in = 32'h7FFFFFFF;
               ov_in = 1'b1;
            end else begin
               re_in = fin.sq_res[31:0];
            end
         end
         default: begin
            re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= fin.valid & ~reset;
      re_ff        <= re_in;
      im_ff        <= im_in;
      zd_ff        <= zd_in;
      ov_ff        <= ov_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_real     = re_ff;
   assign rsp_out_imag     = im_ff;
   assign rsp_zero_divisor = zd_ff;
   assign rsp_overflow     = ov_ff;

   // Every result word has a matching accepted command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start & ~busy, LAT))
      else $error("result without a matching command");

   // A zero divisor never saturates and always gives zero.
   assert property (@(posedge clock)
      rsp_valid && rsp_zero_divisor |-> !rsp_overflow && rsp_out_real == '0
         && rsp_out_imag == '0)
      else $error("zero divisor result not cleared");

   // The square root lane keeps its result within 33 bits.
   assert property (@(posedge clock) disable iff (reset)
      fin.valid && fin.op == cau_pkg::OP_MAG |-> fin.sq_res[63:33] == '0)
      else $error("square root out of range");

endmodule
